// ----- sv/pcm_pkg.sv -----
`timescale 1ns / 1ps
package pcm_pkg;

    typedef enum logic [2:0] {
        DEPTH_8  = 3'd0,
        DEPTH_16 = 3'd1,
        DEPTH_24 = 3'd2,
        DEPTH_32 = 3'd3,
        DEPTH_64 = 3'd4
    } depth_t;

    typedef enum logic [1:0] {
        CFG_KIND     = 2'd0,
        CFG_DEPTH    = 2'd1,
        CFG_ORDER    = 2'd2,
        CFG_UNSIGNED = 2'd3
    } cfg_idx_t;

    localparam int CFG_DATA_W = 3;
    localparam int IN_W       = 64;
    localparam int OUT_W      = 32;

endpackage

// ----- sv/pcm_sample_to_float32.sv -----
`timescale 1ns / 1ps
// channel   | ports                                   | role
// ----------+-----------------------------------------+----------------------
// s_        | s_valid s_ready s_sample_bytes          | raw sample in
// m_        | m_valid m_ready m_sample_float m_format_error | float32 out
// cfg       | cfg_we cfg_index cfg_data               | register writes
//
// one sample per clock sustained while m_ready is high; a sample passes the input
// register, then the result register; each stage holds on output stall
// and reloads in the cycle it empties
// aresetn is synchronous, active low; clears valids and config to defaults
module pcm_sample_to_float32
    import pcm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [IN_W-1:0]       s_sample_bytes,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_W-1:0]      m_sample_float,
    output logic                  m_format_error
);

    logic       kind_reg, order_reg, unsig_reg;
    logic [2:0] depth_reg;

    logic            in_valid_reg;
    logic [IN_W-1:0] in_data_reg;
    logic            out_valid_reg;
    logic [OUT_W-1:0] out_float_reg;
    logic            out_err_reg;

    logic stage2_ready, stage1_ready;
    assign stage2_ready = !out_valid_reg || m_ready;
    assign stage1_ready = !in_valid_reg || stage2_ready;
    assign s_ready = stage1_ready;
    assign m_valid = out_valid_reg;
    assign m_sample_float = out_float_reg;
    assign m_format_error = out_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= 1'b0;
            depth_reg <= DEPTH_16;
            order_reg <= 1'b0;
            unsig_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_KIND:     kind_reg  <= cfg_data[0];
                CFG_DEPTH:    depth_reg <= cfg_data;
                CFG_ORDER:    order_reg <= cfg_data[0];
                CFG_UNSIGNED: unsig_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // integer path: form 32-bit signed value scaled to 2^31 full scale
    logic [31:0] raw_le, raw_be, aligned;
    logic [31:0] mag;
    logic        isign;
    logic [4:0]  msb;
    logic [31:0] norm;
    logic [7:0]  rnd_low;
    logic [23:0] mant24;
    logic [24:0] mant_r;
    logic [7:0]  iexp;
    logic        rup;
    logic [31:0] int_res;

    always_comb begin
        raw_le = in_data_reg[31:0];
        raw_be = '0;
        aligned = '0;
        case (depth_reg)
            DEPTH_8: begin
                aligned = {in_data_reg[7:0], 24'd0};
                if (unsig_reg) aligned[31] = ~aligned[31];
            end
            DEPTH_16: begin
                raw_be[15:0] = order_reg ? {in_data_reg[7:0], in_data_reg[15:8]}
                                         : raw_le[15:0];
                aligned = {raw_be[15:0], 16'd0};
            end
            DEPTH_24: begin
                raw_be[23:0] = order_reg
                    ? {in_data_reg[7:0], in_data_reg[15:8], in_data_reg[23:16]}
                    : raw_le[23:0];
                aligned = {raw_be[23:0], 8'd0};
            end
            default: begin
                raw_be = order_reg ? {in_data_reg[7:0], in_data_reg[15:8],
                                      in_data_reg[23:16], in_data_reg[31:24]}
                                   : raw_le;
                aligned = raw_be;
            end
        endcase
        isign = aligned[31];
        mag = isign ? (~aligned + 32'd1) : aligned;
        msb = '0;
        for (int i = 0; i < 32; i++) begin
            if (mag[i]) msb = 5'(i);
        end
        norm = mag << (5'd31 - msb);
        mant24 = norm[31:8];
        rnd_low = norm[7:0];
        rup = rnd_low[7] && ((rnd_low[6:0] != 7'd0) || mant24[0]);
        mant_r = {1'b0, mant24} + {24'd0, rup};
        iexp = 8'd96 + {3'd0, msb} + {7'd0, mant_r[24]};
        if (mag == 32'd0) int_res = '0;
        else int_res = {isign, iexp, mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
    end

    // double to single narrowing
    logic        dsign;
    logic [10:0] dexp;
    logic [51:0] dfrac;
    logic [52:0] dm;
    logic signed [12:0] be;
    logic [5:0]  sh;
    logic [52:0] dq, dmask, drem, dhalf;
    logic [24:0] dmant;
    logic        dup;
    logic signed [12:0] be2;
    logic [31:0] dbl_res;

    always_comb begin
        dsign = in_data_reg[63];
        dexp  = in_data_reg[62:52];
        dfrac = in_data_reg[51:0];
        dm    = {1'b1, dfrac};
        dmask = '0;
        drem  = '0;
        dhalf = '0;
        be2   = '0;
        be    = $signed({2'b00, dexp}) - 13'sd896;
        if (be >= 13'sd1) sh = 6'd29;
        else if (be < -13'sd32) sh = 6'd63;
        else sh = 6'(13'sd30 - be);
        if (sh >= 6'd54) begin
            dq = '0;
            dup = 1'b0;
        end else begin
            dq    = dm >> sh;
            dmask = (53'd1 << sh) - 53'd1;
            drem  = dm & dmask;
            dhalf = 53'd1 << (sh - 6'd1);
            dup   = (drem > dhalf) || ((drem == dhalf) && dq[0]);
        end
        dmant = dq[24:0] + {24'd0, dup};
        if (dexp == 11'h7FF) begin
            dbl_res = (dfrac == '0) ? {dsign, 31'h7F800000}
                                    : {dsign, 31'h7FC00000 | {8'd0, dfrac[51:29]}};
        end else if (dexp == 11'd0) begin
            dbl_res = {dsign, 31'd0};
        end else if (be >= 13'sd1) begin
            be2 = be + {12'd0, dmant[24]};
            if (be2 >= 13'sd255) dbl_res = {dsign, 31'h7F800000};
            else dbl_res = {dsign, be2[7:0],
                            dmant[24] ? dmant[23:1] : dmant[22:0]};
        end else begin
            dbl_res = {dsign, 7'd0, dmant[23:0]};
        end
    end

    logic [31:0] res_next;
    logic        err_next;

    always_comb begin
        res_next = '0;
        err_next = 1'b0;
        if (kind_reg) begin
            if (depth_reg == DEPTH_32) res_next = in_data_reg[31:0];
            else if (depth_reg == DEPTH_64) res_next = dbl_res;
            else err_next = 1'b1;
        end else if (depth_reg <= DEPTH_32) begin
            res_next = int_res;
        end else begin
            err_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (stage1_ready) in_valid_reg <= s_valid;
            if (stage2_ready) out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage1_ready && s_valid) in_data_reg <= s_sample_bytes;
        if (stage2_ready && in_valid_reg) begin
            out_float_reg <= res_next;
            out_err_reg   <= err_next;
        end
    end

endmodule
